// File: src/height_grid_min_max_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Height grid min/max accumulator assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_GRID_MIN_MAX_ACCUMULATOR_DEFINES_SVH
`define HEIGHT_GRID_MIN_MAX_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HGMM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hgmm assertion failed");

// Next-cycle implication, disabled during reset.
`define HGMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hgmm assertion failed");

`endif

// File: src/hgmm_pkg.sv
// ----------------------------------------------------------------------------
// Height grid package
// Constants, codes and interface types shared by the grid modules.
// ----------------------------------------------------------------------------
package hgmm_pkg;

   localparam int GRID_SIZE = 256;
   localparam int IDX_W = $clog2(GRID_SIZE);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int ORIGIN_QUANTUM = 10;
   localparam logic [23:0] RECIP_TEN = 24'd13421773;
   localparam int RECIP_SHIFT = 27;
   localparam int DIV_STEPS = 25;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int MEM_W = 34;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] CSR_ROBOT_X = 3'd0;
   localparam logic [2:0] CSR_ROBOT_Y = 3'd1;
   localparam logic [2:0] CSR_RANGE_LIMIT = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE = 3'd3;
   localparam logic [2:0] CSR_HEIGHT_LIMIT = 3'd4;

   typedef struct packed {
      logic signed [23:0] robot_x;
      logic signed [23:0] robot_y;
      logic [16:0]        range_limit;
      logic [9:0]         cell_size;
      logic [15:0]        height_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic origin;
      logic div_init;
      logic div_step;
      logic mem_rd;
      logic mem_wr;
      logic clr_start;
      logic clr_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       div_done;
      logic       in_grid;
      logic       clr_done;
   } status_type;

endpackage

// File: src/hgmm_csr.sv
// ----------------------------------------------------------------------------
// Height grid configuration registers
// Holds the robot position, range, cell size and height limit.
// ----------------------------------------------------------------------------
module hgmm_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output hgmm_pkg::cfg_type cfg
);
   import hgmm_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.robot_x <= '0;
         cfg_ff.robot_y <= '0;
         cfg_ff.range_limit <= 17'd1200;
         cfg_ff.cell_size <= 10'd10;
         cfg_ff.height_limit <= 16'd10;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROBOT_X: cfg_ff.robot_x <= csr_wdata;
            CSR_ROBOT_Y: cfg_ff.robot_y <= csr_wdata;
            CSR_RANGE_LIMIT: cfg_ff.range_limit <= csr_wdata[16:0];
            CSR_CELL_SIZE: cfg_ff.cell_size <= csr_wdata[9:0];
            CSR_HEIGHT_LIMIT: cfg_ff.height_limit <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule

// File: src/hgmm_dp.sv
// ----------------------------------------------------------------------------
// Height grid datapath
// Origin, cell index division, cell memory and result formatting.
// ----------------------------------------------------------------------------
module hgmm_dp (
   input  logic                clock,
   input  logic                reset,
   input  hgmm_pkg::cfg_type   cfg,
   input  hgmm_pkg::cmd_type   cmd,
   output hgmm_pkg::status_type status,
   input  logic [1:0]          req_op,
   input  logic signed [23:0]  req_point_x,
   input  logic signed [23:0]  req_point_y,
   input  logic signed [15:0]  req_point_z,
   input  logic                req_point_obstacle,
   input  logic [7:0]          req_cell_row,
   input  logic [7:0]          req_cell_col,
   output logic                rsp_accepted,
   output logic                rsp_cell_valid,
   output logic signed [24:0]  rsp_center_x,
   output logic signed [24:0]  rsp_center_y,
   output logic signed [15:0]  rsp_cell_height,
   output logic                rsp_is_obstacle
);
   import hgmm_pkg::*;

   logic [MEM_W-1:0] mem [0:(1 << ADDR_W)-1];

   logic [1:0]         op_ff;
   logic signed [23:0] px_ff, py_ff;
   logic signed [15:0] pz_ff;
   logic               pobst_ff;
   logic [7:0]         row_ff, col_ff;
   logic [9:0]         cs_ff;
   logic [20:0]        qx_ff, qy_ff;
   logic               sx_ff, sy_ff;
   logic signed [25:0] ox_ff, oy_ff;
   logic [24:0]        dvx_ff, dvy_ff;
   logic [9:0]         remx_ff, remy_ff;
   logic               negx_ff, negy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [MEM_W-1:0]   memq_ff;
   logic               acc_ff, cv_ff, obs_ff;
   logic signed [24:0] cx_ff, cy_ff;
   logic signed [15:0] ch_ff;

   logic [9:0]         cs_in;
   logic [23:0]        magx, magy;
   logic [47:0]        prodx, prody;
   logic [24:0]        tenx, teny;
   logic signed [25:0] cutx, cuty;
   logic signed [25:0] offx, offy;
   logic [10:0]        shx, shy;
   logic               gex, gey;
   logic               okx, oky, in_grid;
   logic [ADDR_W-1:0]  addr;
   logic [MEM_W-1:0]   wr_word;
   logic               seen, mobst;
   logic signed [15:0] lo, hi, nlo, nhi;
   logic signed [17:0] spread;
   logic [17:0]        mulx, muly;
   logic signed [26:0] cxf, cyf;

   assign cs_in = (cfg.cell_size == 10'd0) ? 10'd1 : cfg.cell_size;
   assign magx = cfg.robot_x[23] ? 24'(-cfg.robot_x) : cfg.robot_x;
   assign magy = cfg.robot_y[23] ? 24'(-cfg.robot_y) : cfg.robot_y;
   assign prodx = 48'(magx) * 48'(RECIP_TEN);
   assign prody = 48'(magy) * 48'(RECIP_TEN);
   assign tenx = {1'b0, qx_ff, 3'b000} + {3'b000, qx_ff, 1'b0};
   assign teny = {1'b0, qy_ff, 3'b000} + {3'b000, qy_ff, 1'b0};
   assign cutx = sx_ff ? -$signed({1'b0, tenx}) : $signed({1'b0, tenx});
   assign cuty = sy_ff ? -$signed({1'b0, teny}) : $signed({1'b0, teny});
   assign offx = 26'(px_ff) - ox_ff;
   assign offy = 26'(py_ff) - oy_ff;
   assign shx = {remx_ff, dvx_ff[24]};
   assign shy = {remy_ff, dvy_ff[24]};
   assign gex = shx >= {1'b0, cs_ff};
   assign gey = shy >= {1'b0, cs_ff};

   assign okx = negx_ff ? (dvx_ff == '0) : (int'(dvx_ff) < GRID_SIZE);
   assign oky = negy_ff ? (dvy_ff == '0) : (int'(dvy_ff) < GRID_SIZE);
   assign in_grid = okx && oky;

   assign addr = (op_ff == OP_ADD) ? {dvx_ff[IDX_W-1:0], dvy_ff[IDX_W-1:0]}
                                   : {row_ff[IDX_W-1:0], col_ff[IDX_W-1:0]};

   assign seen = memq_ff[33];
   assign mobst = memq_ff[32];
   assign lo = memq_ff[31:16];
   assign hi = memq_ff[15:0];
   assign nlo = (!seen || pz_ff < lo) ? pz_ff : lo;
   assign nhi = (!seen || pz_ff > hi) ? pz_ff : hi;
   assign wr_word = cmd.clr_wr ? '0 : {1'b1, mobst | pobst_ff, nlo, nhi};
   assign spread = 18'(hi) - 18'(lo);

   assign mulx = 18'(row_ff) * 18'(cs_ff);
   assign muly = 18'(col_ff) * 18'(cs_ff);
   assign cxf = 27'(ox_ff) + $signed({9'd0, mulx}) + $signed({18'd0, cs_ff[9:1]});
   assign cyf = 27'(oy_ff) + $signed({9'd0, muly}) + $signed({18'd0, cs_ff[9:1]});

   assign status.op = op_ff;
   assign status.div_done = (int'(cnt_ff) == DIV_STEPS - 1);
   assign status.in_grid = in_grid;
   assign status.clr_done = (clr_ff == '1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         px_ff <= req_point_x;
         py_ff <= req_point_y;
         pz_ff <= req_point_z;
         pobst_ff <= req_point_obstacle;
         row_ff <= req_cell_row;
         col_ff <= req_cell_col;
         cs_ff <= cs_in;
         qx_ff <= prodx[RECIP_SHIFT+20:RECIP_SHIFT];
         qy_ff <= prody[RECIP_SHIFT+20:RECIP_SHIFT];
         sx_ff <= cfg.robot_x[23];
         sy_ff <= cfg.robot_y[23];
      end
      if (cmd.origin) begin
         ox_ff <= cutx - 26'(cfg.range_limit);
         oy_ff <= cuty - 26'(cfg.range_limit);
      end
      if (cmd.div_init) begin
         negx_ff <= offx[25];
         negy_ff <= offy[25];
         dvx_ff <= offx[25] ? 25'(-offx) : offx[24:0];
         dvy_ff <= offy[25] ? 25'(-offy) : offy[24:0];
         remx_ff <= '0;
         remy_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         remx_ff <= gex ? 10'(shx - {1'b0, cs_ff}) : shx[9:0];
         remy_ff <= gey ? 10'(shy - {1'b0, cs_ff}) : shy[9:0];
         dvx_ff <= {dvx_ff[23:0], gex};
         dvy_ff <= {dvy_ff[23:0], gey};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mem_rd) begin
         memq_ff <= mem[addr];
      end
      if (cmd.clr_wr) begin
         mem[clr_ff] <= wr_word;
      end else if (cmd.mem_wr) begin
         mem[addr] <= wr_word;
      end
      if (cmd.rsp_load) begin
         acc_ff <= 1'b0;
         cv_ff <= 1'b0;
         cx_ff <= '0;
         cy_ff <= '0;
         ch_ff <= '0;
         obs_ff <= 1'b0;
         case (op_ff)
            OP_ADD: acc_ff <= in_grid;
            OP_READ: begin
               cx_ff <= cxf[24:0];
               cy_ff <= cyf[24:0];
               if (seen) begin
                  cv_ff <= 1'b1;
                  ch_ff <= hi;
                  obs_ff <= mobst || (spread > $signed({2'b00, cfg.height_limit}));
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign rsp_accepted = acc_ff;
   assign rsp_cell_valid = cv_ff;
   assign rsp_center_x = cx_ff;
   assign rsp_center_y = cy_ff;
   assign rsp_cell_height = ch_ff;
   assign rsp_is_obstacle = obs_ff;

endmodule

// File: src/hgmm_ctrl.sv
// ----------------------------------------------------------------------------
// Height grid controller
// Sequences origin, division, memory access, clearing and response.
// ----------------------------------------------------------------------------
module hgmm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output hgmm_pkg::cmd_type    cmd,
   input  hgmm_pkg::status_type status
);
   import hgmm_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ORIGIN, S_SETUP, S_DIVIDE, S_LOOKUP, S_MERGE, S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      clr_rsp_ff, clr_rsp_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = 1'b0;
      clr_rsp_in = clr_rsp_ff;
      cmd = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = clr_rsp_ff ? S_RESPOND : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_ORIGIN;
            end
         end
         S_ORIGIN: begin
            cmd.origin = 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.div_init = 1'b1;
            case (status.op)
               OP_ADD: state_in = S_DIVIDE;
               OP_READ: state_in = S_LOOKUP;
               OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  clr_rsp_in = 1'b1;
                  state_in = S_CLEAR;
               end
               default: state_in = S_RESPOND;
            endcase
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (status.op == OP_ADD && !status.in_grid) begin
               state_in = S_RESPOND;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            cmd.mem_wr = (status.op == OP_ADD);
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            clr_rsp_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/height_grid_min_max_accumulator.sv
// Add divides, looks up and merges the cell (a rejected point skips the memory); read looks up a cell,
// and an unused op goes straight to the response. Clear is a one-word-per-cycle sweep of the memory.
// One transaction is handled at a time; add is bounded by the 25-step divider.
// Reset runs the same clearing sweep of all 65536 words with busy high; configuration writes
// are taken meanwhile. Results are one-cycle strobes and cannot be stalled.
// ----------------------------------------------------------------------------
// Height grid min/max accumulator
// Bins points into a square elevation grid around the robot and reports cells.
// ----------------------------------------------------------------------------
module height_grid_min_max_accumulator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [23:0] req_point_x,
   input  logic signed [23:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic               req_point_obstacle,
   input  logic [7:0]         req_cell_row,
   input  logic [7:0]         req_cell_col,
   output logic               rsp_valid,
   output logic               rsp_accepted,
   output logic               rsp_cell_valid,
   output logic signed [24:0] rsp_center_x,
   output logic signed [24:0] rsp_center_y,
   output logic signed [15:0] rsp_cell_height,
   output logic               rsp_is_obstacle,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import hgmm_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   hgmm_csr u_csr (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cfg(cfg)
   );

   hgmm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .status(status)
   );

   hgmm_dp u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .status(status),
      .req_op(req_op), .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_point_obstacle(req_point_obstacle),
      .req_cell_row(req_cell_row), .req_cell_col(req_cell_col),
      .rsp_accepted(rsp_accepted), .rsp_cell_valid(rsp_cell_valid),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_cell_height(rsp_cell_height), .rsp_is_obstacle(rsp_is_obstacle)
   );

endmodule

// File: src/hgmm_checker.sv
// ----------------------------------------------------------------------------
// Height grid port checker
// Checks transaction sequencing and result consistency at the top level ports.
// ----------------------------------------------------------------------------
`include "height_grid_min_max_accumulator_defines.svh"

module hgmm_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_accepted,
   input logic               rsp_cell_valid,
   input logic signed [15:0] rsp_cell_height,
   input logic               rsp_is_obstacle
);

   `HGMM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `HGMM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `HGMM_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `HGMM_ASSERT_NOW(a_unseen_zero, clock, reset, rsp_valid && !rsp_cell_valid, rsp_cell_height == 16'sd0 && !rsp_is_obstacle)
   `HGMM_ASSERT_NOW(a_add_no_cell, clock, reset, rsp_valid && rsp_accepted, !rsp_cell_valid)

endmodule

bind height_grid_min_max_accumulator hgmm_checker u_hgmm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_accepted(rsp_accepted), .rsp_cell_valid(rsp_cell_valid),
   .rsp_cell_height(rsp_cell_height), .rsp_is_obstacle(rsp_is_obstacle)
);
